@@ design/rcp_pkg.sv @@
package rcp_pkg;

    // Parser phase, one per kind of byte expected next
    typedef enum logic [2:0] {
        PH_FIRST,
        PH_ID8,
        PH_ID16_LO,
        PH_ID16_HI,
        PH_MSG,
        PH_EXT
    } t_phase;

    // Field that an extended timestamp replaces
    typedef enum logic [1:0] {
        TGT_NONE,
        TGT_TS,
        TGT_DELTA
    } t_ext_tgt;

    // Header formats
    localparam logic [1:0] FMT_FULL   = 2'd0;
    localparam logic [1:0] FMT_NO_SID = 2'd1;
    localparam logic [1:0] FMT_DELTA  = 2'd2;
    localparam logic [1:0] FMT_NONE   = 2'd3;

    // Basic header id escapes
    localparam logic [5:0] ID_ONE_BYTE = 6'd0;
    localparam logic [5:0] ID_TWO_BYTE = 6'd1;

    localparam logic [16:0] CID_OFFSET = 17'd64;
    localparam logic [31:0] TS_ESCAPE  = 32'h00ff_ffff;

    // Message header lengths and byte positions
    localparam logic [3:0] MSG_LEN_F0 = 4'd11;
    localparam logic [3:0] MSG_LEN_F1 = 4'd7;
    localparam logic [3:0] MSG_LEN_F2 = 4'd3;
    localparam logic [3:0] MSG_LEN_F3 = 4'd0;
    localparam logic [3:0] TS_END     = 4'd3;
    localparam logic [3:0] LEN_END    = 4'd6;
    localparam logic [3:0] TYPE_IDX   = 4'd6;
    localparam logic [3:0] SID_IDX0   = 4'd7;
    localparam logic [3:0] SID_IDX1   = 4'd8;
    localparam logic [3:0] SID_IDX2   = 4'd9;
    localparam logic [3:0] SID_IDX3   = 4'd10;
    localparam logic [3:0] EXT_LEN    = 4'd4;

    // One input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic        status;
        logic [1:0]  format;
        logic [16:0] csid;
        logic [31:0] timestamp;
        logic [31:0] ts_delta;
        logic [23:0] msg_length;
        logic [7:0]  type_id;
        logic [31:0] msg_sid;
        logic        ext_ts;
    } t_result;

    function automatic logic [3:0] msg_len(input logic [1:0] fmt);
        logic [3:0] len;
        unique case (fmt)
            FMT_FULL:   len = MSG_LEN_F0;
            FMT_NO_SID: len = MSG_LEN_F1;
            FMT_DELTA:  len = MSG_LEN_F2;
            default:    len = MSG_LEN_F3;
        endcase
        return len;
    endfunction

endpackage

@@ design/rcp_in_stage.sv @@
module rcp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rcp_pkg::t_in_word i_word,
    input  logic              i_adv,
    output logic              o_valid,
    output rcp_pkg::t_in_word o_word
);
    import rcp_pkg::*;

    logic     r_vld;
    t_in_word r_word;

    // Take a new word when empty or when the held word moves on
    assign o_ready = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Hold the payload until it is consumed
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

@@ design/rcp_decode.sv @@
module rcp_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  rcp_pkg::t_in_word i_word,
    output logic              o_res_valid,
    output rcp_pkg::t_result  o_res
);
    import rcp_pkg::*;

    t_phase      r_phase, n_phase, w_phase;
    logic [3:0]  r_count, n_count, w_count;
    logic [1:0]  r_fmt, n_fmt, w_fmt;
    logic [16:0] r_chunk, n_chunk, w_chunk;
    logic [31:0] r_ts, n_ts, w_ts;
    logic [31:0] r_delta, n_delta, w_delta;
    logic [23:0] r_len, n_len, w_len;
    logic [7:0]  r_type, n_type, w_type;
    logic [31:0] r_sid, n_sid, w_sid;
    t_ext_tgt    r_tgt, n_tgt, w_tgt;

    logic        w_done;
    logic        w_ext;
    logic        w_trunc;
    logic        basic_done;
    logic        msg_done;
    logic [7:0]  b;
    logic [5:0]  id;

    assign b  = i_word.data_byte;
    assign id = b[5:0];

    // Fold the byte into the header fields
    always_comb begin
        w_phase    = r_phase;
        w_count    = r_count;
        w_fmt      = r_fmt;
        w_chunk    = r_chunk;
        w_ts       = r_ts;
        w_delta    = r_delta;
        w_len      = r_len;
        w_type     = r_type;
        w_sid      = r_sid;
        w_tgt      = r_tgt;
        w_done     = 1'b0;
        w_ext      = 1'b0;
        basic_done = 1'b0;
        msg_done   = 1'b0;

        unique case (r_phase)
            PH_ID8: begin
                w_chunk    = {9'd0, b} + CID_OFFSET;
                basic_done = 1'b1;
            end
            PH_ID16_LO: begin
                w_chunk = {9'd0, b};
                w_phase = PH_ID16_HI;
            end
            PH_ID16_HI: begin
                w_chunk    = {1'b0, b, 8'd0} + r_chunk + CID_OFFSET;
                basic_done = 1'b1;
            end
            PH_MSG: begin
                if (r_fmt == FMT_FULL) begin
                    if (r_count < TS_END) begin
                        w_ts = {8'd0, r_ts[15:0], b};
                    end else if (r_count < LEN_END) begin
                        w_len = {r_len[15:0], b};
                    end else if (r_count == TYPE_IDX) begin
                        w_type = b;
                    end else begin
                        case (r_count)
                            SID_IDX0: w_sid[7:0]   = b;
                            SID_IDX1: w_sid[15:8]  = b;
                            SID_IDX2: w_sid[23:16] = b;
                            SID_IDX3: w_sid[31:24] = b;
                            default:  w_sid = r_sid;
                        endcase
                    end
                end else if (r_fmt == FMT_NO_SID) begin
                    if (r_count < TS_END) begin
                        w_delta = {8'd0, r_delta[15:0], b};
                    end else if (r_count < LEN_END) begin
                        w_len = {r_len[15:0], b};
                    end else if (r_count == TYPE_IDX) begin
                        w_type = b;
                    end
                end else if (r_fmt == FMT_DELTA) begin
                    if (r_count < TS_END) begin
                        w_delta = {8'd0, r_delta[15:0], b};
                    end
                end
                w_count  = r_count + 4'd1;
                msg_done = (w_count >= msg_len(r_fmt));
            end
            PH_EXT: begin
                if (r_tgt == TGT_TS) begin
                    w_ts = {r_ts[23:0], b};
                end else begin
                    w_delta = {r_delta[23:0], b};
                end
                w_count = r_count + 4'd1;
                if (w_count >= EXT_LEN) begin
                    w_done = 1'b1;
                    w_ext  = 1'b1;
                end
            end
            default: begin
                // First byte of the basic header: start from a clean header
                w_count = 4'd0;
                w_fmt   = b[7:6];
                w_chunk = 17'd0;
                w_ts    = 32'd0;
                w_delta = 32'd0;
                w_len   = 24'd0;
                w_type  = 8'd0;
                w_sid   = 32'd0;
                w_tgt   = TGT_NONE;
                if (id == ID_ONE_BYTE) begin
                    w_phase = PH_ID8;
                end else if (id == ID_TWO_BYTE) begin
                    w_phase = PH_ID16_LO;
                end else begin
                    w_chunk    = {11'd0, id};
                    basic_done = 1'b1;
                end
            end
        endcase

        // Basic header done: go to the message header
        if (basic_done) begin
            w_phase = PH_MSG;
            w_count = 4'd0;
            if (msg_len(w_fmt) == MSG_LEN_F3) begin
                msg_done = 1'b1;
            end
        end

        // Message header done: read an extended timestamp or finish
        if (msg_done) begin
            if (w_fmt == FMT_FULL && w_ts == TS_ESCAPE) begin
                w_phase = PH_EXT;
                w_tgt   = TGT_TS;
                w_ts    = 32'd0;
                w_count = 4'd0;
            end else if ((w_fmt == FMT_NO_SID || w_fmt == FMT_DELTA)
                         && w_delta == TS_ESCAPE) begin
                w_phase = PH_EXT;
                w_tgt   = TGT_DELTA;
                w_delta = 32'd0;
                w_count = 4'd0;
            end else begin
                w_done = 1'b1;
            end
        end
    end

    assign w_trunc = i_word.buffer_end && !w_done;

    // Next state: restart after any result
    always_comb begin
        if (w_done || w_trunc) begin
            n_phase = PH_FIRST;
            n_count = 4'd0;
            n_fmt   = 2'd0;
            n_chunk = 17'd0;
            n_ts    = 32'd0;
            n_delta = 32'd0;
            n_len   = 24'd0;
            n_type  = 8'd0;
            n_sid   = 32'd0;
            n_tgt   = TGT_NONE;
        end else begin
            n_phase = w_phase;
            n_count = w_count;
            n_fmt   = w_fmt;
            n_chunk = w_chunk;
            n_ts    = w_ts;
            n_delta = w_delta;
            n_len   = w_len;
            n_type  = w_type;
            n_sid   = w_sid;
            n_tgt   = w_tgt;
        end
    end

    // Result word: full header, or all zero with the truncated flag
    always_comb begin
        o_res_valid = w_done || w_trunc;
        o_res       = '0;
        if (w_trunc) begin
            o_res.status = 1'b1;
        end else begin
            o_res.format     = w_fmt;
            o_res.csid       = w_chunk;
            o_res.timestamp  = w_ts;
            o_res.ts_delta   = w_delta;
            o_res.msg_length = w_len;
            o_res.type_id    = w_type;
            o_res.msg_sid    = w_sid;
            o_res.ext_ts     = w_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_count <= 4'd0;
            r_fmt   <= 2'd0;
            r_chunk <= 17'd0;
            r_ts    <= 32'd0;
            r_delta <= 32'd0;
            r_len   <= 24'd0;
            r_type  <= 8'd0;
            r_sid   <= 32'd0;
            r_tgt   <= TGT_NONE;
        end else if (i_go) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_fmt   <= n_fmt;
            r_chunk <= n_chunk;
            r_ts    <= n_ts;
            r_delta <= n_delta;
            r_len   <= n_len;
            r_type  <= n_type;
            r_sid   <= n_sid;
            r_tgt   <= n_tgt;
        end
    end

endmodule

@@ design/rcp_out_reg.sv @@
module rcp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rcp_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output rcp_pkg::t_result o_res
);
    import rcp_pkg::*;

    logic    r_vld;
    t_result r_res;

    // Slot can take a word when empty or being drained this cycle
    assign o_free = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

endmodule

@@ design/rtmp_chunk_header_parser_top.sv @@
// Chunk header decoder: takes the header bytes of a chunk stream one word per
// cycle on a valid/ready channel and gives one result word per complete
// basic-plus-message header (format, chunk stream id with offset, timestamp
// or delta, length, type, little-endian stream id, extended-timestamp flag),
// or a truncated word with all fields zero when a buffer-end byte arrives
// before the header is complete. Each byte passes an input register, a
// combinational decode against the parser state, and an output register, so
// the block sustains one byte per cycle; a result is loaded into the output
// register when the held byte advances, and the block stalls only while
// the result register is full and not being taken.
module rtmp_chunk_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [1:0]  o_format,
    output logic [16:0] o_csid,
    output logic [31:0] o_timestamp,
    output logic [31:0] o_ts_delta,
    output logic [23:0] o_msg_length,
    output logic [7:0]  o_type_id,
    output logic [31:0] o_msg_sid,
    output logic        o_ext_ts
);
    import rcp_pkg::*;

    t_in_word in_word;
    t_in_word held_word;
    logic     held_vld;
    logic     adv;
    logic     out_free;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    assign in_word.data_byte  = i_data_byte;
    assign in_word.buffer_end = i_buffer_end;

    // Decode the held word once the result slot can take its outcome
    assign adv = held_vld && out_free;

    rcp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_word  (in_word),
        .i_adv   (adv),
        .o_valid (held_vld),
        .o_word  (held_word)
    );

    rcp_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (adv),
        .i_word      (held_word),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rcp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_status     = out_res.status;
    assign o_format     = out_res.format;
    assign o_csid       = out_res.csid;
    assign o_timestamp  = out_res.timestamp;
    assign o_ts_delta   = out_res.ts_delta;
    assign o_msg_length = out_res.msg_length;
    assign o_type_id    = out_res.type_id;
    assign o_msg_sid    = out_res.msg_sid;
    assign o_ext_ts     = out_res.ext_ts;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rcp_pkg::*;

    localparam int WD_LIMIT     = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_buffer_end = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_status;
    logic [1:0]  o_format;
    logic [16:0] o_csid;
    logic [31:0] o_timestamp;
    logic [31:0] o_ts_delta;
    logic [23:0] o_msg_length;
    logic [7:0]  o_type_id;
    logic [31:0] o_msg_sid;
    logic        o_ext_ts;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_rx     = 1'b0;
    int   err_cnt     = 0;
    int   stall_cnt   = 0;

    // Header bytes under construction, sent in order
    logic [7:0] hdr_q[$];

    // Decoded headers still to come out of the block
    t_result pending_hdrs[$];

    // Parser state mirrored in the testbench
    t_phase      prs_phase;
    logic [3:0]  prs_cnt;
    logic [1:0]  prs_fmt;
    logic [16:0] prs_cid;
    logic [31:0] prs_ts;
    logic [31:0] prs_delta;
    logic [23:0] prs_len;
    logic [7:0]  prs_type;
    logic [31:0] prs_sid;
    t_ext_tgt    prs_tgt;

    rtmp_chunk_header_parser_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_format     (o_format),
        .o_csid       (o_csid),
        .o_timestamp  (o_timestamp),
        .o_ts_delta   (o_ts_delta),
        .o_msg_length (o_msg_length),
        .o_type_id    (o_type_id),
        .o_msg_sid    (o_msg_sid),
        .o_ext_ts     (o_ext_ts)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Header decoder
    // ---------------------------------------------------------------

    function automatic void clear_parser();
        prs_phase = PH_FIRST;
        prs_cnt   = '0;
        prs_fmt   = '0;
        prs_cid   = '0;
        prs_ts    = '0;
        prs_delta = '0;
        prs_len   = '0;
        prs_type  = '0;
        prs_sid   = '0;
        prs_tgt   = TGT_NONE;
    endfunction

    function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
        case (fmt)
            FMT_FULL:   return MSG_LEN_F0;
            FMT_NO_SID: return MSG_LEN_F1;
            FMT_DELTA:  return MSG_LEN_F2;
            default:    return MSG_LEN_F3;
        endcase
    endfunction

    // Queue a complete header and start over
    function automatic void push_header(input logic ext);
        t_result r;
        r.status     = 1'b0;
        r.format     = prs_fmt;
        r.csid       = prs_cid;
        r.timestamp  = prs_ts;
        r.ts_delta   = prs_delta;
        r.msg_length = prs_len;
        r.type_id    = prs_type;
        r.msg_sid    = prs_sid;
        r.ext_ts     = ext;
        pending_hdrs.push_back(r);
        clear_parser();
    endfunction

    // Message header done: either an extended timestamp follows or the header ends
    function automatic bit msg_done();
        if (prs_fmt == FMT_FULL && prs_ts == TS_ESCAPE) begin
            prs_tgt = TGT_TS;
            prs_ts  = '0;
        end else if ((prs_fmt == FMT_NO_SID || prs_fmt == FMT_DELTA)
                     && prs_delta == TS_ESCAPE) begin
            prs_tgt   = TGT_DELTA;
            prs_delta = '0;
        end else begin
            push_header(1'b0);
            return 1'b1;
        end
        prs_phase = PH_EXT;
        prs_cnt   = '0;
        return 1'b0;
    endfunction

    function automatic bit basic_done();
        prs_phase = PH_MSG;
        prs_cnt   = '0;
        if (hdr_len(prs_fmt) == '0)
            return msg_done();
        return 1'b0;
    endfunction

    // Advance the mirrored parser by one accepted word
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        bit       done;
        t_result  trunc_r;
        done = 1'b0;
        case (prs_phase)
            PH_ID8: begin
                prs_cid = {9'd0, b} + CID_OFFSET;
                done    = basic_done();
            end
            PH_ID16_LO: begin
                prs_cid   = {9'd0, b};
                prs_phase = PH_ID16_HI;
            end
            PH_ID16_HI: begin
                prs_cid = {1'b0, b, 8'd0} + prs_cid + CID_OFFSET;
                done    = basic_done();
            end
            PH_MSG: begin
                case (prs_fmt)
                    FMT_FULL: begin
                        if (prs_cnt < TS_END)
                            prs_ts = {8'd0, prs_ts[15:0], b};
                        else if (prs_cnt < LEN_END)
                            prs_len = {prs_len[15:0], b};
                        else if (prs_cnt == TYPE_IDX)
                            prs_type = b;
                        else if (prs_cnt < MSG_LEN_F0)
                            prs_sid = prs_sid | ({24'd0, b} << (8 * (prs_cnt - SID_IDX0)));
                    end
                    FMT_NO_SID: begin
                        if (prs_cnt < TS_END)
                            prs_delta = {8'd0, prs_delta[15:0], b};
                        else if (prs_cnt < LEN_END)
                            prs_len = {prs_len[15:0], b};
                        else if (prs_cnt == TYPE_IDX)
                            prs_type = b;
                    end
                    FMT_DELTA: begin
                        if (prs_cnt < TS_END)
                            prs_delta = {8'd0, prs_delta[15:0], b};
                    end
                    default: ;
                endcase
                prs_cnt = prs_cnt + 4'd1;
                if (prs_cnt >= hdr_len(prs_fmt))
                    done = msg_done();
            end
            PH_EXT: begin
                if (prs_tgt == TGT_TS)
                    prs_ts = {prs_ts[23:0], b};
                else
                    prs_delta = {prs_delta[23:0], b};
                prs_cnt = prs_cnt + 4'd1;
                if (prs_cnt >= EXT_LEN) begin
                    push_header(1'b1);
                    done = 1'b1;
                end
            end
            default: begin
                clear_parser();
                prs_fmt = b[7:6];
                if (b[5:0] == ID_ONE_BYTE) begin
                    prs_phase = PH_ID8;
                end else if (b[5:0] == ID_TWO_BYTE) begin
                    prs_phase = PH_ID16_LO;
                end else begin
                    prs_cid = {11'd0, b[5:0]};
                    done    = basic_done();
                end
            end
        endcase
        // Buffer ran out mid-header: report truncated and restart
        if (!done && last) begin
            trunc_r        = '0;
            trunc_r.status = 1'b1;
            pending_hdrs.push_back(trunc_r);
            clear_parser();
        end
    endfunction

    // ---------------------------------------------------------------
    // Monitors
    // ---------------------------------------------------------------

    // Predict on every accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            decode_byte(i_data_byte, i_buffer_end);
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_hdrs.size() == 0) begin
                $display("%0t ns: result word expected none actual status %0b csid 0x%0h",
                         $time, o_status, o_csid);
                err_cnt++;
            end else begin
                exp_r = pending_hdrs.pop_front();
                check_field("status", exp_r.status, o_status);
                check_field("format", exp_r.format, o_format);
                check_field("csid", exp_r.csid, o_csid);
                check_field("timestamp", exp_r.timestamp, o_timestamp);
                check_field("ts_delta", exp_r.ts_delta, o_ts_delta);
                check_field("msg_length", exp_r.msg_length, o_msg_length);
                check_field("type_id", exp_r.type_id, o_type_id);
                check_field("msg_sid", exp_r.msg_sid, o_msg_sid);
                check_field("ext_ts", exp_r.ext_ts, o_ext_ts);
            end
        end
    end

    // Drive the result-side ready, with a long hold when asked
    always @(posedge i_clk) begin
        if (hold_rx)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Abort when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WD_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Offer one word; returns at the edge where it is accepted
    task automatic send_word(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_buffer_end <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Lay out one header: basic header, message header, extended timestamp
    task automatic build_header(input logic [1:0] fmt, input logic [5:0] id6,
                                input logic [7:0] id_lo, input logic [7:0] id_hi,
                                input logic [23:0] t24, input logic [23:0] len24,
                                input logic [7:0] typ, input logic [31:0] sid,
                                input logic [31:0] ext32);
        hdr_q.delete();
        hdr_q.push_back({fmt, id6});
        if (id6 == ID_ONE_BYTE) begin
            hdr_q.push_back(id_lo);
        end else if (id6 == ID_TWO_BYTE) begin
            hdr_q.push_back(id_lo);
            hdr_q.push_back(id_hi);
        end
        if (fmt != FMT_NONE) begin
            hdr_q.push_back(t24[23:16]);
            hdr_q.push_back(t24[15:8]);
            hdr_q.push_back(t24[7:0]);
        end
        if (fmt == FMT_FULL || fmt == FMT_NO_SID) begin
            hdr_q.push_back(len24[23:16]);
            hdr_q.push_back(len24[15:8]);
            hdr_q.push_back(len24[7:0]);
            hdr_q.push_back(typ);
        end
        // Stream id goes out low byte first
        if (fmt == FMT_FULL) begin
            hdr_q.push_back(sid[7:0]);
            hdr_q.push_back(sid[15:8]);
            hdr_q.push_back(sid[23:16]);
            hdr_q.push_back(sid[31:24]);
        end
        if (fmt != FMT_NONE && t24 == TS_ESCAPE[23:0]) begin
            hdr_q.push_back(ext32[31:24]);
            hdr_q.push_back(ext32[23:16]);
            hdr_q.push_back(ext32[15:8]);
            hdr_q.push_back(ext32[7:0]);
        end
    endtask

    // Send the laid-out header, marking buffer end at one index (or none)
    task automatic send_header(input int last_at);
        foreach (hdr_q[k])
            send_word(hdr_q[k], k == last_at);
    endtask

    // Full header: two-byte id, escaped timestamp, buffer end on the final byte
    task automatic test_full_header();
        build_header(FMT_FULL, ID_TWO_BYTE, 8'hFF, 8'hFF, TS_ESCAPE[23:0], 24'hFF_FFFF,
                     8'hFF, 32'h80FF_0001, 32'hFF00_0080);
        send_header(hdr_q.size() - 1);
    endtask

    // Formats without stream id, delta only, and basic header only
    task automatic test_short_formats();
        build_header(FMT_NO_SID, ID_ONE_BYTE, 8'hFF, 8'h00, 24'h00_0000, 24'h00_0000,
                     8'h00, 32'h0, 32'h0);
        send_header(-1);
        build_header(FMT_DELTA, 6'h3F, 8'h00, 8'h00, TS_ESCAPE[23:0], 24'h0,
                     8'h00, 32'h0, 32'hFFFF_FFFF);
        send_header(-1);
        build_header(FMT_NONE, 6'd2, 8'h00, 8'h00, 24'h0, 24'h0, 8'h00, 32'h0, 32'h0);
        send_header(0);
    endtask

    // Buffer end before the header completes
    task automatic test_truncation();
        send_word({FMT_FULL, ID_ONE_BYTE}, 1'b1);
        send_word({FMT_NO_SID, 6'd5}, 1'b0);
        send_word(8'hA5, 1'b1);
    endtask

    // Mostly well-formed headers with random content, some truncated, some noise
    task automatic test_random_headers(input int n_words);
        int          sent;
        int          pick;
        int          n_noise;
        int          last_at;
        logic [1:0]  fmt;
        logic [5:0]  id6;
        logic [23:0] t24;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                n_noise = $urandom_range(1, 5);
                for (int k = 0; k < n_noise; k++)
                    send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
                sent += n_noise;
            end else begin
                fmt = 2'($urandom_range(3));
                case ($urandom_range(2))
                    0:       id6 = 6'($urandom_range(2, 63));
                    1:       id6 = ID_ONE_BYTE;
                    default: id6 = ID_TWO_BYTE;
                endcase
                case ($urandom_range(3))
                    0:       t24 = TS_ESCAPE[23:0];
                    1:       t24 = TS_ESCAPE[23:0] - 24'd1;
                    default: t24 = 24'($urandom);
                endcase
                build_header(fmt, id6, 8'($urandom), 8'($urandom), t24, 24'($urandom),
                             8'($urandom), $urandom, $urandom);
                if (pick < 22)
                    last_at = $urandom_range(hdr_q.size() - 1);
                else if (pick < 27)
                    last_at = hdr_q.size() - 1;
                else
                    last_at = -1;
                send_header(last_at);
                sent += hdr_q.size();
            end
        end
    endtask

    // Hold the result side while short headers keep coming, so the input stalls
    task automatic test_output_backpressure();
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
            begin
                for (int k = 0; k < 40; k++) begin
                    build_header(FMT_NONE, 6'($urandom_range(2, 63)), 8'h00, 8'h00, 24'h0,
                                 24'h0, 8'h00, 32'h0, 32'h0);
                    send_header(-1);
                end
            end
        join
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
    endtask

    initial begin
        clear_parser();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(23, 61);
        test_full_header();
        test_short_formats();
        test_truncation();
        test_random_headers(230);

        set_idling(61, 23);
        test_random_headers(230);

        set_idling(0, 0);
        test_random_headers(200);
        test_output_backpressure();

        // Drain all outstanding results, then watch for strays
        i_valid <= 1'b0;
        while (pending_hdrs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
